@@ rtl/k_epsilon_cell_update_assert.svh @@
// Assertion macros for the k-epsilon cell update block
`ifndef K_EPSILON_CELL_UPDATE_ASSERT_SVH
`define K_EPSILON_CELL_UPDATE_ASSERT_SVH

// Same-cycle implication, held off while reset is low
`define KEC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, held off while reset is low
`define KEC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/kec_pkg.sv @@
// Shared types, constants and arithmetic helpers for the k-epsilon cell update
package kec_pkg;

    localparam int FRAC_BITS = 40;
    localparam int VAL_W     = 63;
    localparam int PROD_W    = 2 * VAL_W;
    localparam int IDX_W     = 3;

    localparam logic [VAL_W-1:0] MAXV = {VAL_W{1'b1}};

    // 1e-10 rounded to the fraction grid, never below one LSB
    localparam longint FLOOR_RAW = ((64'sd1 <<< FRAC_BITS) + 64'sd5000000000)
                                   / 64'sd10000000000;
    localparam logic [VAL_W-1:0] FLOOR = (FLOOR_RAW == 0) ? VAL_W'(1) : VAL_W'(FLOOR_RAW);

    // register indexes
    localparam logic [IDX_W-1:0] REG_TIME_STEP  = 3'd0;
    localparam logic [IDX_W-1:0] REG_PRODUCTION = 3'd1;
    localparam logic [IDX_W-1:0] REG_COEFF_ONE  = 3'd2;
    localparam logic [IDX_W-1:0] REG_COEFF_TWO  = 3'd3;
    localparam logic [IDX_W-1:0] REG_COEFF_MU   = 3'd4;

    // reset values
    localparam logic [VAL_W-1:0] RST_TIME_STEP  = 63'd0;
    localparam logic [VAL_W-1:0] RST_PRODUCTION = 63'd10995116278;
    localparam logic [VAL_W-1:0] RST_COEFF_ONE  = 63'd1583296743997;
    localparam logic [VAL_W-1:0] RST_COEFF_TWO  = 63'd2111062325330;
    localparam logic [VAL_W-1:0] RST_COEFF_MU   = 63'd98956046500;

    // divider: one quotient bit per stage
    localparam int DIV_STEPS = VAL_W;

    // pipeline stage numbers (stage 1 holds the accepted request)
    localparam int ST_IN  = 1;
    localparam int ST_T1  = 4;
    localparam int ST_KN  = 5;
    localparam int ST_PE  = ST_KN + 2;
    localparam int ST_R   = ST_PE + DIV_STEPS + 1;
    localparam int ST_KK  = ST_R + 2;
    localparam int ST_T2  = ST_R + 3;
    localparam int ST_EN  = ST_T2 + 1;
    localparam int ST_Q   = ST_EN + DIV_STEPS + 1;
    localparam int ST_OUT = ST_Q + 3;

    // values carried alongside a cell through the pipeline
    typedef struct packed {
        logic             last;
        logic [VAL_W-1:0] k;
        logic [VAL_W-1:0] eps;
        logic [VAL_W-1:0] rho;
        logic             up1;
        logic [VAL_W-1:0] m1;
        logic [VAL_W-1:0] t1;
        logic [VAL_W-1:0] a;
        logic [VAL_W-1:0] b;
        logic [VAL_W-1:0] v;
        logic             up2;
        logic [VAL_W-1:0] m2;
        logic [VAL_W-1:0] k_new;
        logic [VAL_W-1:0] t2;
        logic [VAL_W-1:0] eps_new;
        logic [VAL_W-1:0] vis;
    } t_side;

    // (p >> FRAC_BITS) clamped to the value range
    function automatic logic [VAL_W-1:0] sat_shift(input logic [PROD_W-1:0] p);
        logic [PROD_W-1:0] s;
        s = p >> FRAC_BITS;
        return (|s[PROD_W-1:VAL_W]) ? MAXV : s[VAL_W-1:0];
    endfunction

    // add or subtract a step, clamp, then floor
    function automatic logic [VAL_W-1:0] apply_step(input logic [VAL_W-1:0] base,
                                                    input logic [VAL_W-1:0] t,
                                                    input logic             up);
        logic [VAL_W:0]   sum;
        logic [VAL_W-1:0] r;
        sum = {1'b0, base} + {1'b0, t};
        if (up) begin
            r = sum[VAL_W] ? MAXV : sum[VAL_W-1:0];
        end else begin
            r = (t >= base) ? '0 : base - t;
        end
        return (r < FLOOR) ? FLOOR : r;
    endfunction

endpackage

@@ rtl/kec_if.sv @@
// Channel interfaces: cell requests, results and configuration writes
interface kec_cell_if;
    logic                     valid;
    logic                     ready;
    logic [kec_pkg::VAL_W-1:0] energy_in;
    logic [kec_pkg::VAL_W-1:0] dissipation_in;
    logic [kec_pkg::VAL_W-1:0] density_in;
    logic                     last_cell_in;
    modport source (output valid, energy_in, dissipation_in, density_in, last_cell_in,
                    input ready);
    modport sink (input valid, energy_in, dissipation_in, density_in, last_cell_in,
                  output ready);
endinterface

interface kec_res_if;
    logic                     valid;
    logic                     ready;
    logic [kec_pkg::VAL_W-1:0] energy_out;
    logic [kec_pkg::VAL_W-1:0] dissipation_out;
    logic [kec_pkg::VAL_W-1:0] viscosity_out;
    logic                     last_cell_out;
    modport source (output valid, energy_out, dissipation_out, viscosity_out, last_cell_out,
                    input ready);
    modport sink (input valid, energy_out, dissipation_out, viscosity_out, last_cell_out,
                  output ready);
endinterface

interface kec_cfg_if;
    logic                     valid;
    logic                     ready;
    logic [kec_pkg::IDX_W-1:0] index;
    logic [kec_pkg::VAL_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/kec_mul.sv @@
// Two-stage 63x63 multiplier built from four partial products of the 32-bit and 31-bit operand halves
module kec_mul (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [kec_pkg::VAL_W-1:0]   i_a,
    input  logic [kec_pkg::VAL_W-1:0]   i_b,
    output logic [kec_pkg::PROD_W-1:0]  o_prod
);
    localparam int HI_W = kec_pkg::VAL_W - 32;

    logic [63:0]           r_ll;
    logic [32+HI_W-1:0]    r_lh;
    logic [32+HI_W-1:0]    r_hl;
    logic [2*HI_W-1:0]     r_hh;
    logic [kec_pkg::PROD_W-1:0] r_prod;

    // partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= i_a[31:0] * i_b[31:0];
            r_lh <= i_a[31:0] * i_b[kec_pkg::VAL_W-1:32];
            r_hl <= i_a[kec_pkg::VAL_W-1:32] * i_b[31:0];
            r_hh <= i_a[kec_pkg::VAL_W-1:32] * i_b[kec_pkg::VAL_W-1:32];
        end
    end

    // final sum
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= kec_pkg::PROD_W'(r_ll)
                    + (kec_pkg::PROD_W'(r_lh) << 32)
                    + (kec_pkg::PROD_W'(r_hl) << 32)
                    + (kec_pkg::PROD_W'(r_hh) << 64);
        end
    end

    assign o_prod = r_prod;
endmodule

@@ rtl/kec_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, saturating quotient
module kec_div (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [kec_pkg::PROD_W-1:0]  i_num,
    input  logic [kec_pkg::VAL_W-1:0]   i_den,
    output logic [kec_pkg::VAL_W-1:0]   o_quo
);
    localparam int W = kec_pkg::VAL_W;
    localparam int N = kec_pkg::DIV_STEPS;

    logic [W-1:0] r_rem [0:N];
    logic [W-1:0] r_lq  [0:N];
    logic [W-1:0] r_den [0:N];
    logic         r_ovf [0:N];

    // entry: quotient overflows when the upper half already reaches the divisor
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num[kec_pkg::PROD_W-1:W];
            r_lq[0]  <= i_num[W-1:0];
            r_den[0] <= i_den;
            r_ovf[0] <= (i_num[kec_pkg::PROD_W-1:W] >= i_den);
        end
    end

    // one compare and subtract per stage
    for (genvar g = 1; g <= N; g++) begin : g_step
        logic [W:0] w_t;
        logic       w_ge;
        logic [W:0] w_diff;
        always_comb begin
            w_t    = {r_rem[g-1], r_lq[g-1][W-1]};
            w_ge   = (w_t >= {1'b0, r_den[g-1]});
            w_diff = w_t - {1'b0, r_den[g-1]};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= w_ge ? w_diff[W-1:0] : w_t[W-1:0];
                r_lq[g]  <= {r_lq[g-1][W-2:0], w_ge};
                r_den[g] <= r_den[g-1];
                r_ovf[g] <= r_ovf[g-1];
            end
        end
    end

    assign o_quo = r_ovf[N] ? kec_pkg::MAXV : r_lq[N];
endmodule

@@ rtl/k_epsilon_cell_update.sv @@
// k-epsilon cell update: streaming per-cell k, eps and viscosity pipeline
//
//  channel   dir  modport  handshake    payload
//  i_cell    in   sink     valid/ready  energy_in, dissipation_in, density_in, last_cell_in
//  o_res     out  source   valid/ready  energy_out, dissipation_out, viscosity_out, last_cell_out
//  i_cfg     in   sink     valid/ready  index, data (ready whenever out of reset)
//
//  One cell enters per cycle unless o_res stalls.
//  The pipeline holds two 64-stage bit-per-stage dividers (eps/k' and k'^2/eps') in series
//  with eight two-stage partial-product multipliers and the update stages between them.
//  A stall on o_res freezes every stage at once; nothing is dropped or repeated.
//  Synchronous active-low reset clears valid bits and loads the default coefficients.
`include "k_epsilon_cell_update_assert.svh"

module k_epsilon_cell_update (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kec_cell_if.sink   i_cell,
    kec_res_if.source  o_res,
    kec_cfg_if.sink    i_cfg
);
    localparam int W = kec_pkg::VAL_W;
    localparam int P = kec_pkg::PROD_W;

    logic [W-1:0] r_dt, r_prod, r_c1, r_c2, r_cmu;
    kec_pkg::t_side r_sd  [1:kec_pkg::ST_OUT];
    logic           r_vld [1:kec_pkg::ST_OUT];
    kec_pkg::t_side n_in;
    kec_pkg::t_side n_t1, n_kn, n_t2, n_en, n_out;
    logic           w_adv;

    logic [P-1:0] w_pa, w_pc1, w_pc2, w_pv, w_pe, w_pr, w_pk, w_po;
    logic [W-1:0] w_q1, w_q2;

    // global advance: move unless the result register is held
    assign w_adv        = !r_vld[kec_pkg::ST_OUT] || o_res.ready;
    assign i_cell.ready = w_adv && i_rst_n;
    assign i_cfg.ready  = i_rst_n;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt   <= kec_pkg::RST_TIME_STEP;
            r_prod <= kec_pkg::RST_PRODUCTION;
            r_c1   <= kec_pkg::RST_COEFF_ONE;
            r_c2   <= kec_pkg::RST_COEFF_TWO;
            r_cmu  <= kec_pkg::RST_COEFF_MU;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                kec_pkg::REG_TIME_STEP:  r_dt   <= i_cfg.data;
                kec_pkg::REG_PRODUCTION: r_prod <= i_cfg.data;
                kec_pkg::REG_COEFF_ONE:  r_c1   <= i_cfg.data;
                kec_pkg::REG_COEFF_TWO:  r_c2   <= i_cfg.data;
                kec_pkg::REG_COEFF_MU:   r_cmu  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // entry stage: sign and magnitude of P - eps
    always_comb begin
        n_in      = '0;
        n_in.last = i_cell.last_cell_in;
        n_in.k    = i_cell.energy_in;
        n_in.eps  = i_cell.dissipation_in;
        n_in.rho  = i_cell.density_in;
        n_in.up1  = (r_prod >= i_cell.dissipation_in);
        n_in.m1   = n_in.up1 ? r_prod - i_cell.dissipation_in
                             : i_cell.dissipation_in - r_prod;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= kec_pkg::ST_OUT; s++) r_vld[s] <= 1'b0;
        end else if (w_adv) begin
            r_vld[1] <= i_cell.valid;
            for (int s = 2; s <= kec_pkg::ST_OUT; s++) r_vld[s] <= r_vld[s-1];
        end
    end

    // per-stage results merged into the passing sideband
    always_comb begin
        // k step and constant products
        n_t1    = r_sd[kec_pkg::ST_T1-1];
        n_t1.t1 = kec_pkg::sat_shift(w_pa);
        n_t1.a  = kec_pkg::sat_shift(w_pc1);
        n_t1.b  = kec_pkg::sat_shift(w_pc2);
        n_t1.v  = kec_pkg::sat_shift(w_pv);
        // k' and the eps source term
        n_kn       = r_sd[kec_pkg::ST_KN-1];
        n_kn.k_new = kec_pkg::apply_step(r_sd[kec_pkg::ST_T1].k,
            r_sd[kec_pkg::ST_T1].t1, r_sd[kec_pkg::ST_T1].up1);
        n_kn.up2   = (r_sd[kec_pkg::ST_T1].a >= r_sd[kec_pkg::ST_T1].b);
        n_kn.m2    = n_kn.up2 ? r_sd[kec_pkg::ST_T1].a - r_sd[kec_pkg::ST_T1].b
                              : r_sd[kec_pkg::ST_T1].b - r_sd[kec_pkg::ST_T1].a;
        // eps step and eps'
        n_t2         = r_sd[kec_pkg::ST_T2-1];
        n_t2.t2      = kec_pkg::sat_shift(w_pr);
        n_en         = r_sd[kec_pkg::ST_EN-1];
        n_en.eps_new = kec_pkg::apply_step(r_sd[kec_pkg::ST_T2].eps,
            r_sd[kec_pkg::ST_T2].t2, r_sd[kec_pkg::ST_T2].up2);
        // viscosity
        n_out     = r_sd[kec_pkg::ST_OUT-1];
        n_out.vis = kec_pkg::sat_shift(w_po);
    end

    // sideband pipeline
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sd[1] <= n_in;
            for (int s = 2; s <= kec_pkg::ST_OUT; s++) begin
                case (s)
                    kec_pkg::ST_T1:  r_sd[s] <= n_t1;
                    kec_pkg::ST_KN:  r_sd[s] <= n_kn;
                    kec_pkg::ST_T2:  r_sd[s] <= n_t2;
                    kec_pkg::ST_EN:  r_sd[s] <= n_en;
                    kec_pkg::ST_OUT: r_sd[s] <= n_out;
                    default:         r_sd[s] <= r_sd[s-1];
                endcase
            end
        end
    end

    // multipliers and dividers, all advancing with the pipeline
    kec_mul u_mul_a  (.i_clk, .i_en(w_adv), .i_a(r_sd[1].m1), .i_b(r_dt), .o_prod(w_pa));
    kec_mul u_mul_c1 (.i_clk, .i_en(w_adv), .i_a(r_c1), .i_b(r_prod), .o_prod(w_pc1));
    kec_mul u_mul_c2 (.i_clk, .i_en(w_adv), .i_a(r_c2), .i_b(r_sd[1].eps), .o_prod(w_pc2));
    kec_mul u_mul_v  (.i_clk, .i_en(w_adv), .i_a(r_sd[1].rho), .i_b(r_cmu), .o_prod(w_pv));
    kec_mul u_mul_e  (.i_clk, .i_en(w_adv), .i_a(r_sd[kec_pkg::ST_KN].m2),
                      .i_b(r_sd[kec_pkg::ST_KN].eps), .o_prod(w_pe));
    kec_div u_div_r  (.i_clk, .i_en(w_adv), .i_num(w_pe),
                      .i_den(r_sd[kec_pkg::ST_PE].k_new), .o_quo(w_q1));
    kec_mul u_mul_r  (.i_clk, .i_en(w_adv), .i_a(w_q1), .i_b(r_dt), .o_prod(w_pr));
    kec_mul u_mul_k  (.i_clk, .i_en(w_adv), .i_a(r_sd[kec_pkg::ST_KK].k_new),
                      .i_b(r_sd[kec_pkg::ST_KK].k_new), .o_prod(w_pk));
    kec_div u_div_q  (.i_clk, .i_en(w_adv), .i_num(w_pk),
                      .i_den(r_sd[kec_pkg::ST_EN].eps_new), .o_quo(w_q2));
    kec_mul u_mul_o  (.i_clk, .i_en(w_adv), .i_a(r_sd[kec_pkg::ST_Q].v), .i_b(w_q2),
                      .o_prod(w_po));

    // result register
    assign o_res.valid           = r_vld[kec_pkg::ST_OUT];
    assign o_res.energy_out      = r_sd[kec_pkg::ST_OUT].k_new;
    assign o_res.dissipation_out = r_sd[kec_pkg::ST_OUT].eps_new;
    assign o_res.viscosity_out   = r_sd[kec_pkg::ST_OUT].vis;
    assign o_res.last_cell_out   = r_sd[kec_pkg::ST_OUT].last;

    // checks
    `KEC_ASSERT_NOW(a_floor_held, i_clk, i_rst_n, o_res.valid,
        (o_res.energy_out >= kec_pkg::FLOOR) && (o_res.dissipation_out >= kec_pkg::FLOOR))
    `KEC_ASSERT_NOW(a_div_nonzero, i_clk, i_rst_n, r_vld[kec_pkg::ST_PE],
        r_sd[kec_pkg::ST_PE].k_new != '0)
    `KEC_ASSERT_NEXT(a_stall_freezes, i_clk, i_rst_n, o_res.valid && !o_res.ready,
        $stable(r_vld[kec_pkg::ST_OUT]) && $stable(r_vld[1]))
    `KEC_ASSERT_NEXT(a_entry_valid, i_clk, i_rst_n, i_cell.valid && i_cell.ready, r_vld[1])
endmodule
